// ----- rtl/wms_pkg.sv -----
// Package for the window median block.
// Holds shared widths, state types and the rank unit status struct.
// No dependencies.
package wms_pkg;

	localparam int GRAY_W = 8;
	localparam int COLOR_W = 24;
	localparam int BIT_W = 3;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RANK,
		ST_COLOR,
		ST_RESULT
	} top_state_t;

	typedef enum logic [1:0] {
		RK_IDLE,
		RK_SCAN,
		RK_DRAIN,
		RK_DECIDE
	} rank_state_t;

	typedef struct packed {
		logic              done;
		logic [GRAY_W-1:0] median;
	} rank_stat_t;

endpackage

// ----- rtl/wms_ram.sv -----
// Generic simple dual-port RAM with one write and one registered read port.
// No dependencies.
module wms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 49
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/wms_rank.sv -----
// Rank selection unit: finds the sample at a given rank by a bitwise search,
// sweeping the sample memory once per gray bit. Depends on wms_pkg.
module wms_rank
	import wms_pkg::*;
#(
	parameter int MAX_WINDOW = 7
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]     total,
	input  logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]     rank,
	input  logic [GRAY_W-1:0]                              rdata,
	output logic [$clog2(MAX_WINDOW*MAX_WINDOW)-1:0]       rd_addr,
	output rank_stat_t                                     stat
);

	localparam int DEPTH = MAX_WINDOW * MAX_WINDOW;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rank_state_t       state_q, state_d;
	logic [BIT_W-1:0]  bit_q;
	logic [GRAY_W-1:0] cand_q;
	logic [GRAY_W-1:0] thr;
	logic [GRAY_W-1:0] cand_next;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     less_q;
	logic              vld_s1;
	logic              last_idx;

	assign thr = cand_q | (GRAY_W'(1) << bit_q);
	assign cand_next = (less_q <= rank) ? thr : cand_q;
	assign last_idx = (CW'(idx_q) == (total - CW'(1)));
	assign rd_addr = idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RK_IDLE:   if (start) state_d = RK_SCAN;
			RK_SCAN:   if (last_idx) state_d = RK_DRAIN;
			RK_DRAIN:  state_d = RK_DECIDE;
			RK_DECIDE: state_d = (bit_q == '0) ? RK_IDLE : RK_SCAN;
			default:   state_d = RK_IDLE;
		endcase
	end

	always_comb begin
		stat.done = (state_q == RK_DECIDE) && (bit_q == '0);
		stat.median = cand_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RK_IDLE;
			vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == RK_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && (rdata < thr)) begin
			less_q <= less_q + CW'(1);
		end
		unique case (state_q)
			RK_IDLE: begin
				bit_q <= BIT_W'(GRAY_W - 1);
				cand_q <= '0;
				idx_q <= '0;
				less_q <= '0;
			end
			RK_SCAN: begin
				idx_q <= idx_q + AW'(1);
			end
			RK_DRAIN: begin
			end
			RK_DECIDE: begin
				cand_q <= cand_next;
				bit_q <= bit_q - BIT_W'(1);
				idx_q <= '0;
				less_q <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/window_median_select.sv -----
// Window median select: takes one pixel per cycle while loading a window of T = N*N
// pixels; after the last pixel the rank unit searches for the median, the color memory
// is read at the median level and the result register is loaded. Pixels are stalled
// from the last pixel of a window until its result is loaded. The result register
// holds the transaction until taken. Reset clears control state and sets the window
// side to three; the sample and color memories are not cleared.
module window_median_select
	import wms_pkg::*;
#(
	parameter int MAX_WINDOW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_data,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  logic [GRAY_W-1:0] gray_value,
	input  logic [7:0]        red_value,
	input  logic [7:0]        green_value,
	input  logic [7:0]        blue_value,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [GRAY_W-1:0] median_gray,
	output logic [7:0]        median_red,
	output logic [7:0]        median_green,
	output logic [7:0]        median_blue
);

	localparam int DEPTH = MAX_WINDOW * MAX_WINDOW;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [3:0] MAX_SIDE = 4'(MAX_WINDOW);

	top_state_t         state_q, state_d;
	logic [2:0]         window_size_q;
	logic [CW-1:0]      count_q;
	logic [3:0]         side;
	logic [7:0]         side_sq;
	logic [CW-1:0]      total;
	logic [CW-1:0]      rank;
	logic               accept;
	logic               last_pixel;
	logic               out_free;
	logic [GRAY_W-1:0]  median_q;
	logic [GRAY_W-1:0]  sample_rdata;
	logic [AW-1:0]      sample_raddr;
	logic [COLOR_W-1:0] color_rdata;
	rank_stat_t         rank_stat;
	logic               result_valid_q;
	logic [GRAY_W-1:0]  median_gray_q;
	logic [COLOR_W-1:0] median_color_q;

	always_comb begin
		side = {1'b0, window_size_q};
		if (side < 4'd3) side = 4'd3;
		if (side > MAX_SIDE) side = MAX_SIDE;
		if (!side[0]) side = side - 4'd1;
		side_sq = {4'b0, side} * {4'b0, side};
		total = CW'(side_sq);
		rank = total >> 1;
	end

	assign accept = pixel_valid && !pixel_stall;
	assign last_pixel = (count_q + CW'(1)) == total;
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:   if (accept && last_pixel) state_d = ST_RANK;
			ST_RANK:   if (rank_stat.done) state_d = ST_COLOR;
			ST_COLOR:  state_d = ST_RESULT;
			ST_RESULT: if (out_free) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		pixel_stall = (state_q != ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			window_size_q <= 3'd3;
			count_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				window_size_q <= cfg_data;
				count_q <= '0;
			end else if (accept) begin
				count_q <= last_pixel ? '0 : count_q + CW'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RANK && rank_stat.done) begin
			median_q <= rank_stat.median;
		end
		if (state_q == ST_RESULT && out_free) begin
			median_gray_q <= median_q;
			median_color_q <= color_rdata;
		end
	end

	wms_ram #(
		.WIDTH(GRAY_W),
		.DEPTH(DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (count_q[AW-1:0]),
		.wdata (gray_value),
		.raddr (sample_raddr),
		.rdata (sample_rdata)
	);

	wms_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(256)
	) u_color_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (gray_value),
		.wdata ({red_value, green_value, blue_value}),
		.raddr (median_q),
		.rdata (color_rdata)
	);

	wms_rank #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && last_pixel),
		.total   (total),
		.rank    (rank),
		.rdata   (sample_rdata),
		.rd_addr (sample_raddr),
		.stat    (rank_stat)
	);

	assign result_valid = result_valid_q;
	assign median_gray = median_gray_q;
	assign median_red = median_color_q[23:16];
	assign median_green = median_color_q[15:8];
	assign median_blue = median_color_q[7:0];

endmodule

// ----- test/window_median_checker.sv -----
// Checker for the window median block: watches the configuration write, the pixel channel
// and the result channel, predicts each window's median and color, and compares.
// Depends on wms_pkg for the gray width.
module window_median_checker
	import wms_pkg::*;
#(
	parameter int MAX_WINDOW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_data,
	input  logic              pixel_valid,
	input  logic              pixel_stall,
	input  logic [GRAY_W-1:0] gray_value,
	input  logic [7:0]        red_value,
	input  logic [7:0]        green_value,
	input  logic [7:0]        blue_value,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic [GRAY_W-1:0] median_gray,
	input  logic [7:0]        median_red,
	input  logic [7:0]        median_green,
	input  logic [7:0]        median_blue,
	output int                fail_count,
	output int                outstanding,
	output int                window_total
);

	localparam int DEPTH = MAX_WINDOW * MAX_WINDOW;
	localparam int AW = $clog2(DEPTH);

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} median_t;

	median_t           expected_medians[$];
	logic [GRAY_W-1:0] samples [DEPTH];
	logic [GRAY_W-1:0] ranked [DEPTH];
	logic [23:0]       color_by_level [256];
	logic [2:0]        window_reg;
	logic [GRAY_W-1:0] level;
	logic [GRAY_W-1:0] moved;
	median_t           want;
	int                fill;
	int                total;
	int                i;
	int                j;
	int                mismatches = 0;

	assign fail_count = mismatches;

	function automatic int side_of(input logic [2:0] size);
		int n;
		n = int'(size);
		if (n < 3) n = 3;
		if (n > MAX_WINDOW) n = MAX_WINDOW;
		if (n % 2 == 0) n = n - 1;
		return n;
	endfunction

	task automatic report(input string msg);
		if (mismatches < 100) $display("mismatch: %s", msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_medians.delete();
			fill = 0;
			window_reg = 3'd3;
			outstanding <= 0;
			window_total <= 9;
		end else begin
			if (cfg_write) begin
				window_reg = cfg_data;
				fill = 0;
			end
			if (pixel_valid && !pixel_stall) begin
				total = side_of(window_reg) * side_of(window_reg);
				if (fill >= total) fill = 0;
				samples[AW'(fill)] = gray_value;
				color_by_level[gray_value] = {red_value, green_value, blue_value};
				fill++;
				if (fill == total) begin
					for (i = 0; i < total; i++) ranked[AW'(i)] = samples[AW'(i)];
					for (i = 1; i < total; i++) begin
						moved = ranked[AW'(i)];
						j = i;
						while (j > 0 && ranked[AW'(j-1)] > moved) begin
							ranked[AW'(j)] = ranked[AW'(j-1)];
							j--;
						end
						ranked[AW'(j)] = moved;
					end
					level = ranked[AW'(total/2)];
					want = {level, color_by_level[level]};
					expected_medians.push_back(want);
					fill = 0;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_medians.size() == 0) begin
					report($sformatf("result transaction %h %h %h %h with nothing expected",
						median_gray, median_red, median_green, median_blue));
				end else begin
					want = expected_medians.pop_front();
					if (median_gray !== want.gray)
						report($sformatf("median_gray %h, expected %h", median_gray, want.gray));
					if (median_red !== want.red)
						report($sformatf("median_red %h, expected %h", median_red, want.red));
					if (median_green !== want.green)
						report($sformatf("median_green %h, expected %h", median_green, want.green));
					if (median_blue !== want.blue)
						report($sformatf("median_blue %h, expected %h", median_blue, want.blue));
				end
			end
			outstanding <= expected_medians.size();
			window_total <= side_of(window_reg) * side_of(window_reg);
		end
	end

endmodule

// ----- test/window_median_select_test.sv -----
// Top of the window median testbench: clock, reset, pixel stimulus, result stalls, verdict.
// Instantiates window_median_select and window_median_checker; depends on wms_pkg.
module window_median_select_test
	import wms_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES = 500;
	localparam int RANDOM_ITEMS = 1000;

	localparam logic [31:0] OPENING [22] = '{
		32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h00FFFFFF, 32'h00A55A3C,
		32'hFF000000, 32'hFFFFFFFF, 32'hFF123456, 32'hFFFEDCBA,
		32'hFF000000, 32'h00FFFFFF, 32'hFF00FF00, 32'h01FF00FF, 32'hFFAAAAAA,
		32'hFE555555, 32'h800F0F0F, 32'hFF123456, 32'hFFFFFFFF,
		32'h5500FF00, 32'hAAFF0000, 32'h330000FF, 32'hCCFFFFFF
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [2:0]        cfg_data = 3'd0;
	logic              pixel_valid = 1'b0;
	logic              pixel_stall;
	logic [GRAY_W-1:0] gray_value = '0;
	logic [7:0]        red_value = 8'd0;
	logic [7:0]        green_value = 8'd0;
	logic [7:0]        blue_value = 8'd0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [GRAY_W-1:0] median_gray;
	logic [7:0]        median_red;
	logic [7:0]        median_green;
	logic [7:0]        median_blue;
	int                fail_count;
	int                outstanding;
	int                window_total;
	int                cycles = 0;
	int                burst_left = 0;
	bit                gapless = 1'b0;
	bit                hold_go = 1'b0;
	bit                hold_done = 1'b0;

	always #5 clk = ~clk;

	window_median_select #(.MAX_WINDOW(7)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.gray_value(gray_value),
		.red_value(red_value),
		.green_value(green_value),
		.blue_value(blue_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.median_gray(median_gray),
		.median_red(median_red),
		.median_green(median_green),
		.median_blue(median_blue)
	);

	window_median_checker #(.MAX_WINDOW(7)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.gray_value(gray_value),
		.red_value(red_value),
		.green_value(green_value),
		.blue_value(blue_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.median_gray(median_gray),
		.median_red(median_red),
		.median_green(median_green),
		.median_blue(median_blue),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.window_total(window_total)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_pixel(input logic [31:0] px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gapless ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pixel_valid <= 1'b1;
		{gray_value, red_value, green_value, blue_value} <= px;
		forever begin
			@(posedge clk);
			if (pixel_valid && !pixel_stall) break;
		end
	endtask

	task automatic send_window(input int count);
		int style;
		int k;
		logic [7:0] base;
		logic [7:0] level;
		style = $urandom_range(0, 9);
		base = 8'($urandom_range(0, 255));
		for (k = 0; k < count; k++) begin
			if (style < 6) level = 8'($urandom_range(0, 255));
			else if (style < 9) level = base + 8'($urandom_range(0, 2));
			else level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			send_pixel({level, 24'($urandom)});
		end
	endtask

	task automatic drain_and_settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [2:0] size);
		cfg_write <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : receiver
		int mode;
		int span;
		wait (arst_n);
		forever begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				@(posedge clk);
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 150);
				repeat (span) begin
					@(posedge clk);
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= ($urandom_range(0, 3) != 0);
						default: result_stall <= ~result_stall;
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		int phase;
		int produced;
		int windows;
		int w;
		int k;
		int pick;
		logic [2:0] size;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two full windows at the reset size, then a partial window cut short by a write.
		for (k = 0; k < 22; k++) send_pixel(OPENING[5'(k)]);
		drain_and_settle();
		write_window(3'd0);

		phase = 0;
		produced = 0;
		while (produced < RANDOM_ITEMS) begin
			case (phase)
				0: size = 3'd7;
				1: size = 3'd3;
				2: size = 3'd6;
				3: size = 3'd1;
				4: size = 3'd2;
				5: size = 3'd4;
				6: size = 3'd5;
				7: size = 3'd0;
				default: begin
					pick = $urandom_range(0, 19);
					if (pick < 12) size = 3'($urandom_range(0, 4));
					else if (pick < 17) size = 3'($urandom_range(5, 6));
					else size = 3'd7;
				end
			endcase
			write_window(size);
			gapless = ($urandom_range(0, 3) == 0);
			burst_left = 0;
			if (window_total >= 49) windows = $urandom_range(1, 2);
			else if (window_total >= 25) windows = $urandom_range(2, 4);
			else windows = $urandom_range(4, 12);
			if (phase == 1) begin
				windows = 14;
				hold_go = 1'b1;
			end
			for (w = 0; w < windows; w++) begin
				send_window(window_total);
				produced += window_total;
			end
			if ($urandom_range(0, 3) == 0) send_window($urandom_range(1, window_total - 1));
			drain_and_settle();
			phase++;
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
